[hdl/bus_name_validator_assert.svh]
// ----------------------------------------------------------------------------
// bus_name_validator_assert.svh
// Assertion macros for the bus name validator RTL.
// ----------------------------------------------------------------------------
`ifndef BUS_NAME_VALIDATOR_ASSERT_SVH
`define BUS_NAME_VALIDATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define BNV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BNV_ASSERT_NOW(label, ante, cons, msg)
`define BNV_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/bnv_pkg.sv]
// ----------------------------------------------------------------------------
// bnv_pkg
// Shared constants and types of the bus name validator.
// ----------------------------------------------------------------------------
package bnv_pkg;

  localparam int unsigned MAX_LEN_W   = 9;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned ERR_W       = 3;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 9'd255;
  localparam logic [LEN_W-1:0]     LEN_SAT       = 10'd1023;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SEP     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY_PART = 3'd2;
  localparam logic [ERR_W-1:0] ERR_LEAD_DIGIT = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ILLEGAL    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 3'd5;

  typedef struct packed {
    logic is_digit;
    logic is_legal;
  } char_class_t;

endpackage

[hdl/bnv_classify.sv]
// ----------------------------------------------------------------------------
// bnv_classify
// Character class decode: digit and legal-in-part flags.
// ----------------------------------------------------------------------------
module bnv_classify (
  input  logic [7:0]          char_code,
  input  logic                hyphen_ok,
  output bnv_pkg::char_class_t cls
);

  logic digit;
  logic alpha;

  always_comb begin
    digit = char_code inside {[bnv_pkg::CH_0:bnv_pkg::CH_9]};
    alpha = (char_code inside {[bnv_pkg::CH_UA:bnv_pkg::CH_UZ]}) ||
            (char_code inside {[bnv_pkg::CH_LA:bnv_pkg::CH_LZ]});
    cls.is_digit = digit;
    cls.is_legal = digit || alpha || (char_code == bnv_pkg::CH_UNDER) ||
                   (hyphen_ok && (char_code == bnv_pkg::CH_HYPHEN));
  end

endmodule

[hdl/bus_name_validator.sv]
// ----------------------------------------------------------------------------
// bus_name_validator
// Streaming message-bus name checker, one character word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | direction | words                          | handshake
//  in_     | input     | one character + mode flags     | in_valid / in_ready
//  out_    | output    | name_valid + error_code        | out_valid / out_ready
//  cfg_    | input     | max_name_length                | cfg_valid / cfg_ready
//
//  Throughput: one character word per cycle, unless a held result stalls the input register.
//  Result path: a name's last character is taken into the input register, then
//  its result is written to the result register and shown on out_.
//  Reset: synchronous on rst_n low; name state returns to start of name,
//  max_name_length to MAX_LEN_RST (255 by default).
//  A held result stalls the input register; the input side keeps accepting
//  while that register is empty or advancing.
// ----------------------------------------------------------------------------
`include "bus_name_validator_assert.svh"

module bus_name_validator #(
  parameter logic [bnv_pkg::MAX_LEN_W-1:0] MAX_LEN_RST = bnv_pkg::MAX_LEN_RESET
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_last_char,
  input  logic [7:0]                    in_separator_char,
  input  logic                          in_skip_first,
  input  logic                          in_digit_start_ok,
  input  logic                          in_hyphen_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_name_valid,
  output logic [bnv_pkg::ERR_W-1:0]     out_error_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bnv_pkg::MAX_LEN_W-1:0] cfg_max_name_length
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic [7:0] s1_sep_r;
  logic       s1_skip_r;
  logic       s1_dig_r;
  logic       s1_hyp_r;

  // name state
  logic                          at_start_r;
  logic [7:0]                    sep_r;
  logic                          skip_r;
  logic                          dig_ok_r;
  logic                          hyp_ok_r;
  logic                          sep_seen_r;
  logic                          pnz_r;
  logic [bnv_pkg::ERR_W-1:0]     fpe_r;
  logic [bnv_pkg::LEN_W-1:0]     len_r;
  logic [bnv_pkg::MAX_LEN_W-1:0] max_len_r;

  // result register
  logic                      out_valid_r;
  logic                      out_ok_r;
  logic [bnv_pkg::ERR_W-1:0] out_err_r;

  logic                          s1_adv;
  logic [7:0]                    cur_sep;
  logic                          cur_skip;
  logic                          cur_dig_ok;
  logic                          cur_hyp_ok;
  logic                          sep_seen_nxt;
  logic                          pnz_nxt;
  logic [bnv_pkg::ERR_W-1:0]     fpe_nxt;
  logic [bnv_pkg::LEN_W-1:0]     len_base;
  logic [bnv_pkg::LEN_W-1:0]     len_nxt;
  logic                          is_sep;
  logic [bnv_pkg::ERR_W-1:0]     code_nxt;
  bnv_pkg::char_class_t          cls;

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_name_valid = out_ok_r;
  assign out_error_code = out_err_r;

  bnv_classify u_classify (
    .char_code (s1_char_r),
    .hyphen_ok (cur_hyp_ok),
    .cls       (cls)
  );

  always_comb begin
    cur_sep    = at_start_r ? s1_sep_r  : sep_r;
    cur_skip   = at_start_r ? s1_skip_r : skip_r;
    cur_dig_ok = at_start_r ? s1_dig_r  : dig_ok_r;
    cur_hyp_ok = at_start_r ? s1_hyp_r  : hyp_ok_r;

    len_base     = at_start_r ? '0 : len_r;
    sep_seen_nxt = at_start_r ? 1'b0 : sep_seen_r;
    pnz_nxt      = at_start_r ? 1'b0 : pnz_r;
    fpe_nxt      = at_start_r ? bnv_pkg::ERR_OK : fpe_r;

    len_nxt = (len_base == bnv_pkg::LEN_SAT) ? len_base : len_base + 1'b1;
    is_sep  = (s1_char_r == cur_sep);

    if (is_sep) begin
      sep_seen_nxt = 1'b1;
    end

    if (!(at_start_r && cur_skip)) begin
      if (is_sep) begin
        if (!pnz_nxt && fpe_nxt == bnv_pkg::ERR_OK) begin
          fpe_nxt = bnv_pkg::ERR_EMPTY_PART;
        end
        pnz_nxt = 1'b0;
      end else begin
        if (fpe_nxt == bnv_pkg::ERR_OK) begin
          if (!pnz_nxt && !cur_dig_ok && cls.is_digit) begin
            fpe_nxt = bnv_pkg::ERR_LEAD_DIGIT;
          end else if (!cls.is_legal) begin
            fpe_nxt = bnv_pkg::ERR_ILLEGAL;
          end
        end
        pnz_nxt = 1'b1;
      end
    end

    // trailing empty part
    if (!pnz_nxt && fpe_nxt == bnv_pkg::ERR_OK) begin
      code_nxt = bnv_pkg::ERR_EMPTY_PART;
    end else begin
      code_nxt = fpe_nxt;
    end
    if (!sep_seen_nxt) begin
      code_nxt = bnv_pkg::ERR_NO_SEP;
    end else if (code_nxt == bnv_pkg::ERR_OK &&
                 len_nxt > {1'b0, max_len_r}) begin
      code_nxt = bnv_pkg::ERR_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      at_start_r  <= 1'b1;
      sep_r       <= '0;
      skip_r      <= 1'b0;
      dig_ok_r    <= 1'b0;
      hyp_ok_r    <= 1'b0;
      sep_seen_r  <= 1'b0;
      pnz_r       <= 1'b0;
      fpe_r       <= bnv_pkg::ERR_OK;
      len_r       <= '0;
      max_len_r   <= MAX_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_name_length;
      end

      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_valid_r && s1_adv) begin
        at_start_r <= s1_last_r;
        sep_r      <= cur_sep;
        skip_r     <= cur_skip;
        dig_ok_r   <= cur_dig_ok;
        hyp_ok_r   <= cur_hyp_ok;
        sep_seen_r <= sep_seen_nxt;
        pnz_r      <= pnz_nxt;
        fpe_r      <= fpe_nxt;
        len_r      <= len_nxt;
        if (s1_last_r) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
      s1_sep_r  <= in_separator_char;
      s1_skip_r <= in_skip_first;
      s1_dig_r  <= in_digit_start_ok;
      s1_hyp_r  <= in_hyphen_ok;
    end
    if (s1_valid_r && s1_adv && s1_last_r) begin
      out_ok_r  <= (code_nxt == bnv_pkg::ERR_OK);
      out_err_r <= code_nxt;
    end
  end

  `BNV_ASSERT_NOW(a_ok_matches_code, out_valid_r, out_ok_r == (out_err_r == bnv_pkg::ERR_OK), "name_valid disagrees with error_code")
  `BNV_ASSERT_NOW(a_code_range, out_valid_r, out_err_r <= bnv_pkg::ERR_TOO_LONG, "error_code out of range")
  `BNV_ASSERT_NOW(a_stall_source, !in_ready, s1_valid_r && out_valid_r, "input stalled without a held word")
  `BNV_ASSERT_NEXT(a_last_restarts, s1_valid_r && s1_adv && s1_last_r, at_start_r && out_valid_r, "last character did not close the name")
  `BNV_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_char_r), "input register lost a stalled word")

endmodule
